>>> design/cvea_pkg.sv
`default_nettype none
package cvea_pkg;

	// Fixed-point format and divider shape.
	localparam int QFRAC = 24;
	localparam int DIV_STEPS = 32;

	// Cycles from an accepted transaction to its result strobe.
	localparam int LATENCY = 6 + DIV_STEPS;

	// Command codes.
	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_MIN = 3'd4;
	localparam logic [2:0] CMD_MAX = 3'd5;

	// Register indexes, decoded from the word address.
	localparam logic REG_SCALAR_REAL = 1'b0;
	localparam logic REG_SCALAR_IMAG = 1'b1;

	typedef struct packed {
		logic [2:0]         command;
		logic               complex_mode;
		logic               use_scalar;
		logic signed [31:0] dst_real;
		logic signed [31:0] dst_imag;
		logic signed [31:0] src_real;
		logic signed [31:0] src_imag;
		logic               last_in;
	} operand_t;

	typedef struct packed {
		logic signed [31:0] res_real;
		logic signed [31:0] res_imag;
		logic               div_zero;
		logic               saturated;
		logic               last_out;
	} result_t;

	// Per-transaction control and ready-made values carried past the divider.
	typedef struct packed {
		logic        last;
		logic        is_div;
		logic        clip_re;
		logic        clip_im;
		logic        neg_re;
		logic        neg_im;
		logic        sat;
		logic        dz;
		logic        ovf_re;
		logic        ovf_im;
		logic [31:0] rr;
		logic [31:0] ri;
		logic [40:0] mag_re;
		logic [40:0] mag_im;
	} meta_t;

	// Divider operands: shared denominator and one partial remainder per lane.
	typedef struct packed {
		logic [63:0] den;
		logic [63:0] rem_re;
		logic [63:0] rem_im;
		logic [7:0]  low_re;
		logic [7:0]  low_im;
	} divop_t;

endpackage
`default_nettype wire

>>> design/cvea_front.sv
`default_nettype none
module cvea_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire cvea_pkg::operand_t operand,
	input  wire logic signed [31:0] scalar_real,
	input  wire logic signed [31:0] scalar_imag,
	output logic                    out_valid,
	output cvea_pkg::meta_t         meta,
	output cvea_pkg::divop_t        divop
);

	typedef struct packed {
		logic        last;
		logic        cplx;
		logic        is_mul;
		logic        is_div;
		logic        brneg;
		logic        sat;
		logic        dz;
		logic [31:0] rr;
		logic [31:0] ri;
	} ctl_t;

	// Saturate a 33-bit two's complement sum to 32 bits; bit 32 of the result is the flag.
	function automatic logic [32:0] clip33(input logic [32:0] v);
		logic [32:0] r;
		if (v[32] && !v[31]) begin
			r = {1'b1, 32'h8000_0000};
		end else if (!v[32] && v[31]) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	// Result of a division by zero: full scale with the dividend's sign, or zero for a zero dividend.
	function automatic logic [31:0] zdiv(input logic [31:0] x);
		logic [31:0] r;
		if (x[31]) begin
			r = 32'h8000_0000;
		end else if (x != 32'd0) begin
			r = 32'h7FFF_FFFF;
		end else begin
			r = 32'd0;
		end
		return r;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: capture the operands, choosing the scalar or the source.
	logic [2:0]         cmd_s1;
	logic               cplx_s1, last_s1;
	logic signed [31:0] dr_s1, di_s1, br_s1, bi_s1;

	always_ff @(posedge clk) begin
		cmd_s1  <= operand.command;
		cplx_s1 <= operand.complex_mode;
		last_s1 <= operand.last_in;
		dr_s1   <= operand.dst_real;
		di_s1   <= operand.dst_imag;
		br_s1   <= operand.use_scalar ? scalar_real : operand.src_real;
		bi_s1   <= operand.use_scalar ? scalar_imag : operand.src_imag;
	end

	// Stage 2 logic: add, subtract, min, max and division by zero finish here.
	logic [32:0] add_re, add_im, sub_re, sub_im, c_re, c_im;
	ctl_t        ctl_d;

	assign add_re = {dr_s1[31], dr_s1} + {br_s1[31], br_s1};
	assign add_im = {di_s1[31], di_s1} + {bi_s1[31], bi_s1};
	assign sub_re = {dr_s1[31], dr_s1} - {br_s1[31], br_s1};
	assign sub_im = {di_s1[31], di_s1} - {bi_s1[31], bi_s1};

	always_comb begin
		c_re = '0;
		c_im = '0;
		ctl_d.last   = last_s1;
		ctl_d.cplx   = cplx_s1;
		ctl_d.brneg  = br_s1[31];
		ctl_d.is_mul = (cmd_s1 == cvea_pkg::CMD_MUL);
		ctl_d.dz     = (cmd_s1 == cvea_pkg::CMD_DIV) && (br_s1 == 32'sd0)
			&& (!cplx_s1 || (bi_s1 == 32'sd0));
		ctl_d.is_div = (cmd_s1 == cvea_pkg::CMD_DIV) && !ctl_d.dz;
		ctl_d.rr     = dr_s1;
		ctl_d.ri     = di_s1;
		ctl_d.sat    = 1'b0;
		unique case (cmd_s1)
			cvea_pkg::CMD_ADD: begin
				c_re = clip33(add_re);
				c_im = clip33(add_im);
				ctl_d.rr  = c_re[31:0];
				ctl_d.sat = c_re[32];
				if (cplx_s1) begin
					ctl_d.ri  = c_im[31:0];
					ctl_d.sat = c_re[32] | c_im[32];
				end
			end
			cvea_pkg::CMD_SUB: begin
				c_re = clip33(sub_re);
				c_im = clip33(sub_im);
				ctl_d.rr  = c_re[31:0];
				ctl_d.sat = c_re[32];
				if (cplx_s1) begin
					ctl_d.ri  = c_im[31:0];
					ctl_d.sat = c_re[32] | c_im[32];
				end
			end
			cvea_pkg::CMD_MIN: begin
				ctl_d.rr = (dr_s1 > br_s1) ? br_s1 : dr_s1;
			end
			cvea_pkg::CMD_MAX: begin
				ctl_d.rr = (dr_s1 < br_s1) ? br_s1 : dr_s1;
			end
			cvea_pkg::CMD_DIV: begin
				if (ctl_d.dz) begin
					ctl_d.rr = zdiv(dr_s1);
					if (cplx_s1) begin
						ctl_d.ri = zdiv(di_s1);
					end
				end
			end
			default: begin
				ctl_d.rr = dr_s1;
			end
		endcase
	end

	// Stage 2: the six products and the divisor magnitude for real division.
	logic signed [63:0] p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2, p_bbr_s2, p_bbi_s2;
	logic [31:0]        babs_s2;
	logic [31:0]        dr_s2;
	ctl_t               ctl_s2;

	always_ff @(posedge clk) begin
		p_rr_s2  <= dr_s1 * br_s1;
		p_ii_s2  <= di_s1 * bi_s1;
		p_ir_s2  <= di_s1 * br_s1;
		p_ri_s2  <= dr_s1 * bi_s1;
		p_bbr_s2 <= br_s1 * br_s1;
		p_bbi_s2 <= bi_s1 * bi_s1;
		babs_s2  <= br_s1[31] ? (~br_s1 + 32'd1) : br_s1;
		dr_s2    <= dr_s1;
		ctl_s2   <= ctl_d;
	end

	// Stage 3: combine products into numerators and the denominator.
	logic [64:0] e_rr, e_ii, e_ir, e_ri;
	logic [64:0] re_d, im_d;
	logic [63:0] den_d;

	assign e_rr = {p_rr_s2[63], p_rr_s2};
	assign e_ii = {p_ii_s2[63], p_ii_s2};
	assign e_ir = {p_ir_s2[63], p_ir_s2};
	assign e_ri = {p_ri_s2[63], p_ri_s2};

	always_comb begin
		if (ctl_s2.is_div) begin
			re_d = ctl_s2.cplx ? (e_rr + e_ii) : {{33{dr_s2[31]}}, dr_s2};
			im_d = e_ir - e_ri;
		end else begin
			re_d = ctl_s2.cplx ? (e_rr - e_ii) : e_rr;
			im_d = e_ir + e_ri;
		end
		den_d = ctl_s2.cplx ? (p_bbr_s2 + p_bbi_s2) : {32'd0, babs_s2};
	end

	logic [64:0] re_s3, im_s3;
	logic [63:0] den_s3;
	ctl_t        ctl_s3;

	always_ff @(posedge clk) begin
		re_s3  <= re_d;
		im_s3  <= im_d;
		den_s3 <= den_d;
		ctl_s3 <= ctl_s2;
	end

	// Stage 4: sign and magnitude of the numerators.
	logic [64:0] re_neg, im_neg;
	logic [63:0] mag_re_s4, mag_im_s4, den_s4;
	logic        neg_re_s4, neg_im_s4;
	ctl_t        ctl_s4;

	assign re_neg = ~re_s3 + 65'd1;
	assign im_neg = ~im_s3 + 65'd1;

	always_ff @(posedge clk) begin
		mag_re_s4 <= re_s3[64] ? re_neg[63:0] : re_s3[63:0];
		mag_im_s4 <= im_s3[64] ? im_neg[63:0] : im_s3[63:0];
		neg_re_s4 <= (ctl_s3.is_div && !ctl_s3.cplx) ? (re_s3[64] ^ ctl_s3.brneg) : re_s3[64];
		neg_im_s4 <= im_s3[64];
		den_s4    <= den_s3;
		ctl_s4    <= ctl_s3;
	end

	// Stage 5: product rounding, quotient range check and divider setup.
	logic [64:0] rnd_re, rnd_im;

	assign rnd_re = {1'b0, mag_re_s4} + (65'd1 << (cvea_pkg::QFRAC - 1));
	assign rnd_im = {1'b0, mag_im_s4} + (65'd1 << (cvea_pkg::QFRAC - 1));

	always_ff @(posedge clk) begin
		meta.last    <= ctl_s4.last;
		meta.is_div  <= ctl_s4.is_div;
		meta.clip_re <= ctl_s4.is_mul | ctl_s4.is_div;
		meta.clip_im <= (ctl_s4.is_mul | ctl_s4.is_div) & ctl_s4.cplx;
		meta.neg_re  <= neg_re_s4;
		meta.neg_im  <= neg_im_s4;
		meta.sat     <= ctl_s4.sat;
		meta.dz      <= ctl_s4.dz;
		meta.ovf_re  <= {8'd0, mag_re_s4} >= {den_s4, 8'd0};
		meta.ovf_im  <= {8'd0, mag_im_s4} >= {den_s4, 8'd0};
		meta.rr      <= ctl_s4.rr;
		meta.ri      <= ctl_s4.ri;
		meta.mag_re  <= rnd_re[64:cvea_pkg::QFRAC];
		meta.mag_im  <= rnd_im[64:cvea_pkg::QFRAC];
		divop.den    <= den_s4;
		divop.rem_re <= {8'd0, mag_re_s4[63:8]};
		divop.rem_im <= {8'd0, mag_im_s4[63:8]};
		divop.low_re <= mag_re_s4[7:0];
		divop.low_im <= mag_im_s4[7:0];
	end

	assign out_valid = v_s5;

endmodule
`default_nettype wire

>>> design/cvea_div.sv
`default_nettype none
module cvea_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire cvea_pkg::meta_t  in_meta,
	input  wire cvea_pkg::divop_t in_op,
	output logic                  out_valid,
	output cvea_pkg::meta_t       out_meta,
	output logic [31:0]           q_re,
	output logic [31:0]           q_im
);

	localparam int N = cvea_pkg::DIV_STEPS;

	// Registered stages 1..N, and the view of each stage's inputs 0..N-1.
	logic            v_s    [1:N];
	cvea_pkg::meta_t meta_s [1:N];
	logic [63:0]     den_s  [1:N];
	logic [63:0]     rre_s  [1:N];
	logic [63:0]     rim_s  [1:N];
	logic [7:0]      lre_s  [1:N];
	logic [7:0]      lim_s  [1:N];
	logic [31:0]     qre_s  [1:N];
	logic [31:0]     qim_s  [1:N];

	logic            v_i    [0:N-1];
	cvea_pkg::meta_t meta_i [0:N-1];
	logic [63:0]     den_i  [0:N-1];
	logic [63:0]     rre_i  [0:N-1];
	logic [63:0]     rim_i  [0:N-1];
	logic [7:0]      lre_i  [0:N-1];
	logic [7:0]      lim_i  [0:N-1];
	logic [31:0]     qre_i  [0:N-1];
	logic [31:0]     qim_i  [0:N-1];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_step
			logic [64:0] t_re, t_im, d_re, d_im;
			logic        ge_re, ge_im;

			// Stage input: the transaction entering, or the previous stage.
			if (k == 0) begin : g_first
				assign v_i[k]    = in_valid;
				assign meta_i[k] = in_meta;
				assign den_i[k]  = in_op.den;
				assign rre_i[k]  = in_op.rem_re;
				assign rim_i[k]  = in_op.rem_im;
				assign lre_i[k]  = in_op.low_re;
				assign lim_i[k]  = in_op.low_im;
				assign qre_i[k]  = '0;
				assign qim_i[k]  = '0;
			end else begin : g_next
				assign v_i[k]    = v_s[k];
				assign meta_i[k] = meta_s[k];
				assign den_i[k]  = den_s[k];
				assign rre_i[k]  = rre_s[k];
				assign rim_i[k]  = rim_s[k];
				assign lre_i[k]  = lre_s[k];
				assign lim_i[k]  = lim_s[k];
				assign qre_i[k]  = qre_s[k];
				assign qim_i[k]  = qim_s[k];
			end

			// One restoring step per lane: shift in a dividend bit, try the subtract.
			assign t_re  = {rre_i[k], lre_i[k][7]};
			assign t_im  = {rim_i[k], lim_i[k][7]};
			assign d_re  = t_re - {1'b0, den_i[k]};
			assign d_im  = t_im - {1'b0, den_i[k]};
			assign ge_re = t_re >= {1'b0, den_i[k]};
			assign ge_im = t_im >= {1'b0, den_i[k]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k+1] <= 1'b0;
				end else begin
					v_s[k+1] <= v_i[k];
				end
			end

			always_ff @(posedge clk) begin
				meta_s[k+1] <= meta_i[k];
				den_s[k+1]  <= den_i[k];
				rre_s[k+1]  <= ge_re ? d_re[63:0] : t_re[63:0];
				rim_s[k+1]  <= ge_im ? d_im[63:0] : t_im[63:0];
				lre_s[k+1]  <= {lre_i[k][6:0], 1'b0};
				lim_s[k+1]  <= {lim_i[k][6:0], 1'b0};
				qre_s[k+1]  <= {qre_i[k][30:0], ge_re};
				qim_s[k+1]  <= {qim_i[k][30:0], ge_im};
			end
		end
	endgenerate

	assign out_valid = v_s[N];
	assign out_meta  = meta_s[N];
	assign q_re      = qre_s[N];
	assign q_im      = qim_s[N];

endmodule
`default_nettype wire

>>> design/cvea_clip.sv
`default_nettype none
module cvea_clip (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire cvea_pkg::meta_t meta,
	input  wire logic [31:0]     q_re,
	input  wire logic [31:0]     q_im,
	output logic                 out_valid,
	output cvea_pkg::result_t    result
);

	// Clip a sign and magnitude to 32 bits; bit 32 of the result is the flag.
	function automatic logic [32:0] clip_sm(input logic neg, input logic [40:0] mag);
		logic [32:0] r;
		logic [31:0] m;
		m = ~mag[31:0] + 32'd1;
		if (neg) begin
			if (mag > 41'h0_8000_0000) begin
				r = {1'b1, 32'h8000_0000};
			end else begin
				r = {1'b0, m};
			end
		end else begin
			if (mag > 41'h0_7FFF_FFFF) begin
				r = {1'b1, 32'h7FFF_FFFF};
			end else begin
				r = {1'b0, mag[31:0]};
			end
		end
		return r;
	endfunction

	// Pick the rounded product or the quotient, then clip both parts.
	logic [40:0] m_re, m_im;
	logic [32:0] c_re, c_im;
	cvea_pkg::result_t res_d;

	always_comb begin
		if (meta.is_div) begin
			m_re = meta.ovf_re ? (41'd1 << 32) : {9'd0, q_re};
			m_im = meta.ovf_im ? (41'd1 << 32) : {9'd0, q_im};
		end else begin
			m_re = meta.mag_re;
			m_im = meta.mag_im;
		end
		c_re = clip_sm(meta.neg_re, m_re);
		c_im = clip_sm(meta.neg_im, m_im);
		res_d.res_real  = meta.clip_re ? c_re[31:0] : meta.rr;
		res_d.res_imag  = meta.clip_im ? c_im[31:0] : meta.ri;
		res_d.div_zero  = meta.dz;
		res_d.saturated = meta.sat | (meta.clip_re & c_re[32]) | (meta.clip_im & c_im[32]);
		res_d.last_out  = meta.last;
	end

	logic              vld_sn;
	cvea_pkg::result_t res_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else begin
			vld_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_sn <= res_d;
	end

	assign out_valid = vld_sn;
	assign result    = res_sn;

endmodule
`default_nettype wire

>>> design/complex_vector_element_alu.sv
`default_nettype none
// Complex vector element ALU. One transaction per clock: start is taken whenever it is
// high (busy is never raised), and each result appears on result with result_valid high
// for exactly one cycle, in the order its transactions were accepted.
// Five front stages do operand selection, the 32x32 multiplies, sums and rounding; a
// 32-stage restoring divider computes one quotient bit per stage for both lanes;
// a final stage clips and registers the result. Every command takes the same path.
// The scalar operand registers sit on the APB port at 0x0 (real) and 0x4 (imaginary)
// and should only be written while no transaction is in flight.
module complex_vector_element_alu (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire cvea_pkg::operand_t operand,
	output logic                    result_valid,
	output cvea_pkg::result_t       result
);

	logic signed [31:0] scalar_real_q, scalar_imag_q;
	logic               in_valid;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scalar_real_q <= '0;
			scalar_imag_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				cvea_pkg::REG_SCALAR_REAL: scalar_real_q <= pwdata;
				cvea_pkg::REG_SCALAR_IMAG: scalar_imag_q <= pwdata;
			endcase
		end
	end

	assign prdata   = (paddr[2] == cvea_pkg::REG_SCALAR_IMAG) ? scalar_imag_q : scalar_real_q;
	assign pready   = 1'b1;
	assign busy     = 1'b0;
	assign in_valid = start && !busy;

	// Datapath.
	logic             f_valid, d_valid;
	cvea_pkg::meta_t  f_meta, d_meta;
	cvea_pkg::divop_t f_op;
	logic [31:0]      q_re, q_im;

	cvea_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.operand    (operand),
		.scalar_real(scalar_real_q),
		.scalar_imag(scalar_imag_q),
		.out_valid  (f_valid),
		.meta       (f_meta),
		.divop      (f_op)
	);

	cvea_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_meta  (f_meta),
		.in_op    (f_op),
		.out_valid(d_valid),
		.out_meta (d_meta),
		.q_re     (q_re),
		.q_im     (q_im)
	);

	cvea_clip u_clip (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d_valid),
		.meta     (d_meta),
		.q_re     (q_re),
		.q_im     (q_im),
		.out_valid(result_valid),
		.result   (result)
	);

`ifndef SYNTHESIS
	// Every accepted transaction yields its result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(cvea_pkg::LATENCY) result_valid)
		else $error("result missing after fixed latency");

	// No result appears without a transaction accepted one latency earlier.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(cvea_pkg::LATENCY) !result_valid)
		else $error("result without an accepted transaction");

	// The end-of-vector mark travels with its transaction.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operand.last_in) |-> ##(cvea_pkg::LATENCY) result.last_out)
		else $error("last mark lost in the pipeline");

	// A division by zero is never also reported as clipped.
	a_dz_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.div_zero) |-> !result.saturated)
		else $error("division by zero flagged as saturated");
`endif

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

// Keeps the expected result elements in order and compares arrivals against them.
class alu_scoreboard;
	cvea_pkg::result_t pending[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	function void note_operand(cvea_pkg::result_t exp_res);
		pending.push_back(exp_res);
	endfunction

	task mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("ERROR: %s got %h expected %h", field, got, want);
		errors++;
	endtask

	task check_result(cvea_pkg::result_t got);
		cvea_pkg::result_t want;
		if (pending.size() == 0) begin
			mismatch("unexpected result", got.res_real, 32'h0);
			return;
		end
		want = pending.pop_front();
		if (got.res_real !== want.res_real) mismatch("res_real", got.res_real, want.res_real);
		if (got.res_imag !== want.res_imag) mismatch("res_imag", got.res_imag, want.res_imag);
		if (got.div_zero !== want.div_zero)
			mismatch("div_zero", 32'(got.div_zero), 32'(want.div_zero));
		if (got.saturated !== want.saturated)
			mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
		if (got.last_out !== want.last_out)
			mismatch("last_out", 32'(got.last_out), 32'(want.last_out));
	endtask
endclass

module tb;
	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	cvea_pkg::operand_t operand;
	logic result_valid;
	cvea_pkg::result_t result;

	alu_scoreboard board;
	logic signed [31:0] scalar_re;
	logic signed [31:0] scalar_im;
	int idle_pct;

	complex_vector_element_alu dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .operand(operand),
		.result_valid(result_valid), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Clip a signed magnitude to the 32-bit range, flagging when it is cut.
	function automatic logic signed [31:0] clip_mag(bit neg, logic [127:0] mag, ref bit sat);
		if (neg) begin
			if (mag > 128'h8000_0000) begin
				sat = 1'b1;
				return 32'sh8000_0000;
			end
			return -mag[31:0];
		end
		if (mag > 128'h7FFF_FFFF) begin
			sat = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		return mag[31:0];
	endfunction

	function automatic logic signed [31:0] clip_wide(logic signed [127:0] v, ref bit sat);
		return clip_mag(v < 0, v < 0 ? -v : v, sat);
	endfunction

	// Round a Q16.48 product term to Q8.24, ties away from zero, then clip.
	function automatic logic signed [31:0] round_q(logic signed [127:0] v, ref bit sat);
		logic [127:0] m;
		m = v < 0 ? -v : v;
		m = (m + (128'd1 << (cvea_pkg::QFRAC - 1))) >> cvea_pkg::QFRAC;
		return clip_mag(v < 0, m, sat);
	endfunction

	// Quotient scaled by 2^24, truncated toward zero, then clipped.
	function automatic logic signed [31:0] quot_q(logic signed [127:0] num,
			logic [127:0] den, ref bit sat);
		logic [127:0] m;
		m = num < 0 ? -num : num;
		m = (m << cvea_pkg::QFRAC) / den;
		return clip_mag(num < 0, m, sat);
	endfunction

	function automatic logic signed [31:0] div_zero_value(logic signed [31:0] v);
		if (v > 0) return 32'sh7FFF_FFFF;
		if (v < 0) return 32'sh8000_0000;
		return 32'sd0;
	endfunction

	// Computes the result element that one operand transaction must produce.
	function automatic cvea_pkg::result_t predict_element(cvea_pkg::operand_t op);
		cvea_pkg::result_t r;
		bit sat;
		logic signed [127:0] dr, di, br, bi;
		logic [127:0] den;
		sat = 1'b0;
		dr = op.dst_real;
		di = op.dst_imag;
		br = op.use_scalar ? scalar_re : op.src_real;
		bi = op.use_scalar ? scalar_im : op.src_imag;
		r.res_real = op.dst_real;
		r.res_imag = op.dst_imag;
		r.div_zero = 1'b0;
		r.last_out = op.last_in;
		case (op.command)
			cvea_pkg::CMD_MIN: r.res_real = dr > br ? br[31:0] : dr[31:0];
			cvea_pkg::CMD_MAX: r.res_real = dr < br ? br[31:0] : dr[31:0];
			cvea_pkg::CMD_ADD: begin
				r.res_real = clip_wide(dr + br, sat);
				if (op.complex_mode) r.res_imag = clip_wide(di + bi, sat);
			end
			cvea_pkg::CMD_SUB: begin
				r.res_real = clip_wide(dr - br, sat);
				if (op.complex_mode) r.res_imag = clip_wide(di - bi, sat);
			end
			cvea_pkg::CMD_MUL: begin
				if (op.complex_mode) begin
					r.res_real = round_q(dr * br - di * bi, sat);
					r.res_imag = round_q(di * br + dr * bi, sat);
				end else begin
					r.res_real = round_q(dr * br, sat);
				end
			end
			cvea_pkg::CMD_DIV: begin
				if (op.complex_mode) begin
					den = br * br + bi * bi;
					if (den == 0) begin
						r.div_zero = 1'b1;
						r.res_real = div_zero_value(op.dst_real);
						r.res_imag = div_zero_value(op.dst_imag);
					end else begin
						r.res_real = quot_q(dr * br + di * bi, den, sat);
						r.res_imag = quot_q(di * br - dr * bi, den, sat);
					end
				end else if (br == 0) begin
					r.div_zero = 1'b1;
					r.res_real = div_zero_value(op.dst_real);
				end else begin
					r.res_real = quot_q(br < 0 ? -dr : dr, br < 0 ? -br : br, sat);
				end
			end
			default: ;
		endcase
		r.saturated = sat;
		return r;
	endfunction

	// Register write through the APB port: setup cycle, then access cycle.
	task automatic write_scalar(logic reg_idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == cvea_pkg::REG_SCALAR_REAL) scalar_re = value;
		else scalar_im = value;
	endtask

	task automatic set_scalar(logic [31:0] re, logic [31:0] im);
		write_scalar(cvea_pkg::REG_SCALAR_REAL, re);
		write_scalar(cvea_pkg::REG_SCALAR_IMAG, im);
	endtask

	// Presents one operand and holds it until the block accepts it.
	task automatic send_operand(cvea_pkg::operand_t op);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operand <= op;
		do @(posedge clk); while (busy);
		board.note_operand(predict_element(op));
	endtask

	task automatic stop_sending();
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for every outstanding result, then at least the pipeline depth once more.
	task automatic drain();
		stop_sending();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (cvea_pkg::LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return $urandom_range(1) ? 32'h0100_0000 : 32'hFF00_0000;
			4, 5: return {{8{$urandom_range(1) ? 1'b1 : 1'b0}}, 24'($urandom)};
			6: return 32'($signed(24'($urandom)));
			default: return $urandom;
		endcase
	endfunction

	function automatic cvea_pkg::operand_t random_operand();
		cvea_pkg::operand_t op;
		op.command = $urandom_range(15) == 0 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
		op.complex_mode = 1'($urandom_range(1));
		op.use_scalar = $urandom_range(3) == 0;
		op.dst_real = pick_value();
		op.dst_imag = pick_value();
		op.src_real = pick_value();
		op.src_imag = $urandom_range(7) == 0 ? 32'h0 : pick_value();
		if (op.command == cvea_pkg::CMD_DIV && $urandom_range(9) == 0) begin
			op.src_real = 32'h0;
			if ($urandom_range(1)) op.src_imag = 32'h0;
		end
		op.last_in = $urandom_range(7) == 0;
		return op;
	endfunction

	function automatic cvea_pkg::operand_t make_operand(logic [2:0] cmd, bit cplx, bit scal,
			logic [31:0] dr, logic [31:0] di, logic [31:0] sr, logic [31:0] si, bit last);
		cvea_pkg::operand_t op;
		op.command = cmd;
		op.complex_mode = cplx;
		op.use_scalar = scal;
		op.dst_real = dr;
		op.dst_imag = di;
		op.src_real = sr;
		op.src_imag = si;
		op.last_in = last;
		return op;
	endfunction

	// Result checking at each strobe.
	always @(posedge clk) begin
		if (arst_n && result_valid) board.check_result(result);
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		board = new();
		scalar_re = '0;
		scalar_im = '0;
		idle_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		operand = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every command, division by zero and unused codes.
		set_scalar(32'h7FFF_FFFF, 32'h8000_0000);
		send_operand(make_operand(cvea_pkg::CMD_ADD, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_SUB, 1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
		send_operand(make_operand(cvea_pkg::CMD_MUL, 1'b1, 1'b0, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_MUL, 1'b0, 1'b1, 32'h0100_0000, 32'h1234_5678,
			32'h0, 32'h0, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_MUL, 1'b1, 1'b0, 32'h0000_0001, 32'h0,
			32'h0080_0000, 32'h0, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_DIV, 1'b0, 1'b0, 32'h0500_0000, 32'h1,
			32'h0, 32'h5, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_DIV, 1'b0, 1'b0, 32'hFB00_0000, 32'h1,
			32'h0, 32'h5, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_DIV, 1'b1, 1'b0, 32'h0, 32'h0300_0000,
			32'h0, 32'h0, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_DIV, 1'b1, 1'b0, 32'h0200_0000, 32'h0100_0000,
			32'h0100_0000, 32'hFF00_0000, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_DIV, 1'b0, 1'b0, 32'h8000_0000, 32'h0,
			32'hFFFF_FFFF, 32'h0, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_DIV, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0, 32'h0, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_MIN, 1'b1, 1'b0, 32'h8000_0000, 32'h1,
			32'h7FFF_FFFF, 32'h2, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_MAX, 1'b1, 1'b1, 32'h8000_0000, 32'h1,
			32'h0, 32'h2, 1'b1));
		send_operand(make_operand(3'd6, 1'b1, 1'b0, 32'h1111_1111, 32'h2222_2222,
			32'h3, 32'h4, 1'b0));
		send_operand(make_operand(3'd7, 1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h3, 32'h4, 1'b1));
		drain();
		set_scalar(32'h0, 32'h0);
		send_operand(make_operand(cvea_pkg::CMD_DIV, 1'b0, 1'b1, 32'h0100_0000, 32'h0,
			32'h1, 32'h1, 1'b0));
		send_operand(make_operand(cvea_pkg::CMD_DIV, 1'b1, 1'b1, 32'hFF00_0000, 32'h0100_0000,
			32'h1, 32'h1, 1'b1));
		drain();

		// Random phases under different scalar settings and sender idling.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_scalar(32'h8000_0000, 32'h7FFF_FFFF);
				1: set_scalar(32'h0100_0000, 32'h0);
				2: set_scalar(pick_value(), pick_value());
				default: set_scalar($urandom, $urandom);
			endcase
			case (phase % 3)
				0: idle_pct = 0;
				1: idle_pct = 82;
				default: idle_pct = 13;
			endcase
			for (int n = 0; n < 155; n++) send_operand(random_operand());
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
